### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RFAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property on the same edge.
`define RFAE_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

### src/rfae_pkg.sv
// ----------------------------------------------------------------------------
// rfae_pkg
// Shared constants and command codes of the rectangle fill engine.
// ----------------------------------------------------------------------------
package rfae_pkg;

  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned ADDR_BITS  = 2 * COORD_BITS;
  localparam int unsigned DIM        = 1 << COORD_BITS;
  localparam int unsigned CH_BITS    = 16;
  localparam int unsigned PIX_BITS   = 4 * CH_BITS;
  localparam int unsigned COUNT_BITS = 13;

  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_AVG  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

endpackage

### src/rect_fill_average_engine_unit.sv
// ----------------------------------------------------------------------------
// Rectangle fill / running-average engine
// 64x64 texture of four 16-bit channels; fill, average-fill and pixel read.
// ----------------------------------------------------------------------------
// After reset the block clears all 4096 texture words and accepts no
// request. A read passes a read and a latch step. A fill writes one clipped
// pixel per cycle, set by the single write port of the texture memory. An
// average-fill works each pixel as one read and one latch step, then for
// each of the four channels one shared multiplier step, one add step, a
// shared radix-2 divider giving 16 quotient bits and one write-back step,
// one channel after the other, then one write step. One request is worked
// at a time; the next is accepted as soon as the result register is loaded.
`include "assert_macros.svh"

module rect_fill_average_engine_unit
  import rfae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [5:0]            in_rect_x,
  input  logic [5:0]            in_rect_y,
  input  logic [6:0]            in_rect_width,
  input  logic [6:0]            in_rect_height,
  input  logic [15:0]           in_avg_count,
  input  logic [15:0]           in_color_r,
  input  logic [15:0]           in_color_g,
  input  logic [15:0]           in_color_b,
  input  logic [15:0]           in_color_a,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_pixel_r,
  output logic [15:0]           out_pixel_g,
  output logic [15:0]           out_pixel_b,
  output logic [15:0]           out_pixel_a,
  output logic [COUNT_BITS-1:0] out_pixels_written
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_LAT, S_MUL, S_DINIT, S_DIV, S_WB, S_WR, S_DONE
  } state_t;

  state_t                  state_r;
  logic [ADDR_BITS-1:0]    clr_r;
  op_t                     op_r;
  logic [COORD_BITS-1:0]   y0_r, xi_r, yi_r;
  logic [COORD_BITS:0]     x1_r, y1_r;
  logic [16:0]             d_r;
  logic [15:0]             n_r;
  logic [PIX_BITS-1:0]     col_r, pix_r;
  logic [1:0]              ch_r;
  logic [31:0]             prod_r;
  logic [16:0]             rem_r;
  logic [15:0]             q_r;
  logic [3:0]              step_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic                    out_valid_r;
  logic [PIX_BITS-1:0]     out_pix_r;
  logic [COUNT_BITS-1:0]   out_cnt_r;

  logic [PIX_BITS-1:0]     mem [DIM*DIM];
  logic [PIX_BITS-1:0]     rd_data_r;
  logic                    we;
  logic [ADDR_BITS-1:0]    wa;
  logic [PIX_BITS-1:0]     wd;
  logic [ADDR_BITS-1:0]    ra;

  logic [COORD_BITS+1:0]   xsum, ysum;
  logic [32:0]             num;
  logic [17:0]             trial;
  logic                    ge;
  logic [COORD_BITS:0]     yn, xn;

  always_comb begin
    we = (state_r == S_WR) || (state_r == S_CLR);
    wa = (state_r == S_CLR) ? clr_r : {yi_r, xi_r};
    wd = (state_r == S_CLR) ? '0 : pix_r;
    ra = {yi_r, xi_r};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_comb begin
    xsum  = {2'b00, in_rect_x} + {1'b0, in_rect_width};
    ysum  = {2'b00, in_rect_y} + {1'b0, in_rect_height};
    num   = {1'b0, prod_r} + {17'd0, col_r[{ch_r, 4'b0000} +: 16]}
            + {17'd0, d_r[16:1]};
    trial = {rem_r, q_r[15]};
    ge    = trial >= {1'b0, d_r};
    yn    = {1'b0, yi_r} + 1'b1;
    xn    = {1'b0, xi_r} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op_t'(in_opcode);
            y0_r    <= in_rect_y;
            xi_r    <= in_rect_x;
            yi_r    <= in_rect_y;
            x1_r    <= (xsum > (COORD_BITS+2)'(DIM)) ? (COORD_BITS+1)'(DIM)
                                                     : xsum[COORD_BITS:0];
            y1_r    <= (ysum > (COORD_BITS+2)'(DIM)) ? (COORD_BITS+1)'(DIM)
                                                     : ysum[COORD_BITS:0];
            d_r     <= {1'b0, in_avg_count} + 17'd1;
            n_r     <= in_avg_count;
            col_r   <= {in_color_a, in_color_b, in_color_g, in_color_r};
            pix_r   <= {in_color_a, in_color_b, in_color_g, in_color_r};
            count_r <= '0;
            unique case (op_t'(in_opcode))
              OP_READ: state_r <= S_RD;
              OP_NOP:  state_r <= S_DONE;
              default: begin
                if (in_rect_width == '0 || in_rect_height == '0) begin
                  state_r <= S_DONE;
                end else if (op_t'(in_opcode) == OP_FILL) begin
                  state_r <= S_WR;
                end else begin
                  state_r <= S_RD;
                end
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_LAT;
        end
        S_LAT: begin
          pix_r <= rd_data_r;
          ch_r  <= 2'd0;
          state_r <= (op_r == OP_READ) ? S_DONE : S_MUL;
        end
        S_MUL: begin
          prod_r  <= {16'd0, pix_r[{ch_r, 4'b0000} +: 16]} * {16'd0, n_r};
          state_r <= S_DINIT;
        end
        S_DINIT: begin
          rem_r   <= num[32:16];
          q_r     <= num[15:0];
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= ge ? 17'(trial - {1'b0, d_r}) : trial[16:0];
          q_r    <= {q_r[14:0], ge};
          step_r <= step_r + 1'b1;
          if (&step_r) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          pix_r[{ch_r, 4'b0000} +: 16] <= q_r;
          ch_r <= ch_r + 1'b1;
          state_r <= (&ch_r) ? S_WR : S_MUL;
        end
        S_WR: begin
          count_r <= count_r + 1'b1;
          pix_r   <= col_r;
          if (yn < y1_r) begin
            yi_r    <= yn[COORD_BITS-1:0];
            state_r <= (op_r == OP_AVG) ? S_RD : S_WR;
          end else if (xn < x1_r) begin
            yi_r    <= y0_r;
            xi_r    <= xn[COORD_BITS-1:0];
            state_r <= (op_r == OP_AVG) ? S_RD : S_WR;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_pix_r   <= (op_r == OP_READ) ? pix_r : '0;
            out_cnt_r   <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_pixel_r        = out_pix_r[15:0];
  assign out_pixel_g        = out_pix_r[31:16];
  assign out_pixel_b        = out_pix_r[47:32];
  assign out_pixel_a        = out_pix_r[63:48];
  assign out_pixels_written = out_cnt_r;

  `RFAE_ASSERT_IMP(a_rem_below_divisor, state_r == S_DIV, rem_r < d_r,
    "divider remainder reached divisor")
  `RFAE_ASSERT_IMP(a_count_bound, out_valid, out_pixels_written <= 13'd4096,
    "pixel count above texture size")
  `RFAE_ASSERT_IMP(a_fill_no_pixel, out_valid && out_pixels_written != '0,
    out_pixel_r == '0 && out_pixel_a == '0, "fill result carries pixel data")
  `RFAE_ASSERT(a_clear_stalls, (state_r == S_CLR) |-> in_stall,
    "request taken during texture clear")

endmodule
